// ----- rtl/rgbhk_pkg.sv -----
// Shared types and constants of the RGB histogram with chroma key.
package rgbhk_pkg;

    localparam int BIN_COUNT_DEF  = 256;
    localparam int COUNT_BITS_DEF = 18;
    localparam int CNT_OUT_W      = 18;
    localparam int CHAN_W         = 8;
    localparam int CFG_ADDR_W     = 3;
    localparam int FIFO_DEPTH     = 3;
    localparam int LVL_W          = 2;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] CFG_RED_LOW    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RED_HIGH   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GREEN_LOW  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_GREEN_HIGH = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_BLUE_LOW   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_BLUE_HIGH  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_FILL_LEVEL = 3'd6;

    localparam logic [CHAN_W-1:0] RST_RED_LOW    = 8'd0;
    localparam logic [CHAN_W-1:0] RST_RED_HIGH   = 8'd30;
    localparam logic [CHAN_W-1:0] RST_GREEN_LOW  = 8'd0;
    localparam logic [CHAN_W-1:0] RST_GREEN_HIGH = 8'd50;
    localparam logic [CHAN_W-1:0] RST_BLUE_LOW   = 8'd200;
    localparam logic [CHAN_W-1:0] RST_BLUE_HIGH  = 8'd255;
    localparam logic [CHAN_W-1:0] RST_FILL_LEVEL = 8'd255;

    // Operation on one histogram bank for one item.
    typedef struct packed {
        logic inc;
        logic rd;
        logic clr;
    } t_bank_op;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              keyed;
    } t_pix;

    typedef struct packed {
        t_pix                 pix;
        logic [CNT_OUT_W-1:0] count_red;
        logic [CNT_OUT_W-1:0] count_green;
        logic [CNT_OUT_W-1:0] count_blue;
    } t_result;

endpackage

// ----- rtl/rgbhk_hist_bank.sv -----
// One histogram: bin memory with read-modify-write, forwarding and per-bin valid flags.
module rgbhk_hist_bank #(
    parameter int BIN_COUNT  = rgbhk_pkg::BIN_COUNT_DEF,
    parameter int COUNT_BITS = rgbhk_pkg::COUNT_BITS_DEF,
    localparam int AW        = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_go,
    input  rgbhk_pkg::t_bank_op             i_op,
    input  logic [AW-1:0]                   i_addr,
    output logic [rgbhk_pkg::CNT_OUT_W-1:0] o_count
);

    logic [COUNT_BITS-1:0] r_mem [BIN_COUNT];
    logic [COUNT_BITS-1:0] r_rd_q;
    logic [BIN_COUNT-1:0]  r_valid;
    logic                  r_s1_go;
    rgbhk_pkg::t_bank_op   r_s1_op;
    logic [AW-1:0]         r_s1_addr;
    logic                  r_fwd_en;
    logic [AW-1:0]         r_fwd_addr;
    logic [COUNT_BITS-1:0] r_fwd_data;

    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] wr_data;
    logic                  wr_en;
    logic [COUNT_BITS-1:0] rd_count;

    // Memory: registered read at accept, write back from stage one.
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rd_q <= r_mem[i_addr];
        end
        if (wr_en) begin
            r_mem[r_s1_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_go  <= 1'b0;
            r_fwd_en <= 1'b0;
            r_valid  <= '0;
        end else begin
            r_s1_go  <= i_go;
            r_fwd_en <= wr_en;
            if (wr_en) begin
                r_valid[r_s1_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_op    <= i_op;
        r_s1_addr  <= i_addr;
        r_fwd_addr <= r_s1_addr;
        r_fwd_data <= wr_data;
    end

    // Take the bin just written when the read raced that write.
    always_comb begin
        if (r_fwd_en && (r_fwd_addr == r_s1_addr)) begin
            cur = r_fwd_data;
        end else if (r_valid[r_s1_addr]) begin
            cur = r_rd_q;
        end else begin
            cur = '0;
        end
    end

    assign wr_en = r_s1_go & (r_s1_op.inc | (r_s1_op.rd & r_s1_op.clr));

    always_comb begin
        if (r_s1_op.inc) begin
            wr_data = (cur == {COUNT_BITS{1'b1}}) ? cur : cur + COUNT_BITS'(1);
        end else begin
            wr_data = '0;
        end
    end

    assign rd_count = r_s1_op.rd ? cur : '0;

    generate
        if (COUNT_BITS >= rgbhk_pkg::CNT_OUT_W) begin : g_trunc
            assign o_count = rd_count[rgbhk_pkg::CNT_OUT_W-1:0];
        end else begin : g_ext
            assign o_count = {{(rgbhk_pkg::CNT_OUT_W - COUNT_BITS){1'b0}}, rd_count};
        end
    endgenerate

endmodule

// ----- rtl/rgbhk_key.sv -----
// Key range registers and the chroma key decision.
module rgbhk_key (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wen,
    input  logic [rgbhk_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [rgbhk_pkg::CHAN_W-1:0]     i_cfg_data,
    input  logic [rgbhk_pkg::CHAN_W-1:0]     i_red,
    input  logic [rgbhk_pkg::CHAN_W-1:0]     i_green,
    input  logic [rgbhk_pkg::CHAN_W-1:0]     i_blue,
    output rgbhk_pkg::t_pix                  o_pix
);

    logic [rgbhk_pkg::CHAN_W-1:0] r_red_low;
    logic [rgbhk_pkg::CHAN_W-1:0] r_red_high;
    logic [rgbhk_pkg::CHAN_W-1:0] r_green_low;
    logic [rgbhk_pkg::CHAN_W-1:0] r_green_high;
    logic [rgbhk_pkg::CHAN_W-1:0] r_blue_low;
    logic [rgbhk_pkg::CHAN_W-1:0] r_blue_high;
    logic [rgbhk_pkg::CHAN_W-1:0] r_fill_level;
    logic                         keyed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_low    <= rgbhk_pkg::RST_RED_LOW;
            r_red_high   <= rgbhk_pkg::RST_RED_HIGH;
            r_green_low  <= rgbhk_pkg::RST_GREEN_LOW;
            r_green_high <= rgbhk_pkg::RST_GREEN_HIGH;
            r_blue_low   <= rgbhk_pkg::RST_BLUE_LOW;
            r_blue_high  <= rgbhk_pkg::RST_BLUE_HIGH;
            r_fill_level <= rgbhk_pkg::RST_FILL_LEVEL;
        end else if (i_cfg_wen) begin
            case (i_cfg_addr)
                rgbhk_pkg::CFG_RED_LOW:    r_red_low    <= i_cfg_data;
                rgbhk_pkg::CFG_RED_HIGH:   r_red_high   <= i_cfg_data;
                rgbhk_pkg::CFG_GREEN_LOW:  r_green_low  <= i_cfg_data;
                rgbhk_pkg::CFG_GREEN_HIGH: r_green_high <= i_cfg_data;
                rgbhk_pkg::CFG_BLUE_LOW:   r_blue_low   <= i_cfg_data;
                rgbhk_pkg::CFG_BLUE_HIGH:  r_blue_high  <= i_cfg_data;
                rgbhk_pkg::CFG_FILL_LEVEL: r_fill_level <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // An empty range (low above high) never matches.
    assign keyed = (i_red   >= r_red_low)   && (i_red   <= r_red_high)   &&
                   (i_green >= r_green_low) && (i_green <= r_green_high) &&
                   (i_blue  >= r_blue_low)  && (i_blue  <= r_blue_high);

    always_comb begin
        if (keyed) begin
            o_pix.red   = r_fill_level;
            o_pix.green = r_fill_level;
            o_pix.blue  = r_fill_level;
        end else begin
            o_pix.red   = i_red;
            o_pix.green = i_green;
            o_pix.blue  = i_blue;
        end
        o_pix.keyed = keyed;
    end

endmodule

// ----- rtl/rgbhk_out_fifo.sv -----
// Small result queue that decouples the pipeline from the output handshake.
module rgbhk_out_fifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  rgbhk_pkg::t_result          i_data,
    input  logic                        i_ready,
    output logic                        o_valid,
    output rgbhk_pkg::t_result          o_data,
    output logic [rgbhk_pkg::LVL_W-1:0] o_level
);

    localparam logic [rgbhk_pkg::LVL_W-1:0] LAST = rgbhk_pkg::LVL_W'(rgbhk_pkg::FIFO_DEPTH - 1);

    rgbhk_pkg::t_result           r_mem [rgbhk_pkg::FIFO_DEPTH];
    logic [rgbhk_pkg::LVL_W-1:0]  r_wp;
    logic [rgbhk_pkg::LVL_W-1:0]  r_rp;
    logic [rgbhk_pkg::LVL_W-1:0]  r_level;
    logic                         pop;

    assign o_valid = (r_level != '0);
    assign o_data  = r_mem[r_rp];
    assign o_level = r_level;
    assign pop     = o_valid & i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == LAST) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == LAST) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_level <= r_level + 1'b1;
                2'b01:   r_level <= r_level - 1'b1;
                default: r_level <= r_level;
            endcase
        end
    end

endmodule

// ----- rtl/rgb_histogram_chroma_key.sv -----
// Path: an accepted item is registered in stage one, then pushed into the result queue.
// Throughput: one item per cycle while o_in_ready is high; each bank's read-modify-write forwards
//   the value written at an edge to the item whose read was issued at that edge.
// Ready depends only on registered state: a three-entry result queue plus stage one.
// Reset: key ranges and fill level take their defaults, all bins read as zero at once
//   through per-bin valid flags; no clearing pass, items are taken right after reset.
module rgb_histogram_chroma_key #(
    parameter int BIN_COUNT  = rgbhk_pkg::BIN_COUNT_DEF,
    parameter int COUNT_BITS = rgbhk_pkg::COUNT_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_wen,
    input  logic [rgbhk_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [rgbhk_pkg::CHAN_W-1:0]     i_cfg_data,
    // request channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_req_type,
    input  logic [rgbhk_pkg::CHAN_W-1:0]     i_pix_red,
    input  logic [rgbhk_pkg::CHAN_W-1:0]     i_pix_green,
    input  logic [rgbhk_pkg::CHAN_W-1:0]     i_pix_blue,
    input  logic [rgbhk_pkg::CHAN_W-1:0]     i_bin_index,
    input  logic                             i_clear_after_read,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [rgbhk_pkg::CHAN_W-1:0]     o_out_red,
    output logic [rgbhk_pkg::CHAN_W-1:0]     o_out_green,
    output logic [rgbhk_pkg::CHAN_W-1:0]     o_out_blue,
    output logic                             o_was_keyed,
    output logic [rgbhk_pkg::CNT_OUT_W-1:0]  o_count_red,
    output logic [rgbhk_pkg::CNT_OUT_W-1:0]  o_count_green,
    output logic [rgbhk_pkg::CNT_OUT_W-1:0]  o_count_blue
);

    localparam int AW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
    localparam logic [rgbhk_pkg::CHAN_W:0] BIN_LIM = (rgbhk_pkg::CHAN_W + 1)'(BIN_COUNT);

    logic                         accept;
    logic                         is_pix;
    logic                         idx_ok;
    rgbhk_pkg::t_bank_op          op_red;
    rgbhk_pkg::t_bank_op          op_green;
    rgbhk_pkg::t_bank_op          op_blue;
    logic [AW-1:0]                addr_red;
    logic [AW-1:0]                addr_green;
    logic [AW-1:0]                addr_blue;
    rgbhk_pkg::t_pix              key_pix;
    rgbhk_pkg::t_pix              n_s1_pix;
    rgbhk_pkg::t_pix              r_s1_pix;
    logic                         r_s1_v;
    rgbhk_pkg::t_result           s1_res;
    rgbhk_pkg::t_result           head;
    logic [rgbhk_pkg::LVL_W-1:0]  level;
    logic [rgbhk_pkg::CNT_OUT_W-1:0] cnt_red;
    logic [rgbhk_pkg::CNT_OUT_W-1:0] cnt_green;
    logic [rgbhk_pkg::CNT_OUT_W-1:0] cnt_blue;

    // Admit an item only when the queue can still hold it and the one in stage one.
    assign o_in_ready = ({1'b0, level} + (rgbhk_pkg::LVL_W + 1)'(r_s1_v))
                        < (rgbhk_pkg::LVL_W + 1)'(rgbhk_pkg::FIFO_DEPTH);
    assign accept     = i_in_valid & o_in_ready;

    assign is_pix = (i_req_type == rgbhk_pkg::REQ_PIXEL);
    assign idx_ok = ({1'b0, i_bin_index} < BIN_LIM);

    // Per channel: a pixel bumps its own bin, a read hits the requested bin.
    // Channel values past the last bin bump nothing.
    always_comb begin
        op_red.inc   = is_pix & ({1'b0, i_pix_red} < BIN_LIM);
        op_green.inc = is_pix & ({1'b0, i_pix_green} < BIN_LIM);
        op_blue.inc  = is_pix & ({1'b0, i_pix_blue} < BIN_LIM);
        op_red.rd    = !is_pix & idx_ok;
        op_green.rd  = !is_pix & idx_ok;
        op_blue.rd   = !is_pix & idx_ok;
        op_red.clr   = i_clear_after_read;
        op_green.clr = i_clear_after_read;
        op_blue.clr  = i_clear_after_read;
        addr_red     = is_pix ? i_pix_red[AW-1:0]   : i_bin_index[AW-1:0];
        addr_green   = is_pix ? i_pix_green[AW-1:0] : i_bin_index[AW-1:0];
        addr_blue    = is_pix ? i_pix_blue[AW-1:0]  : i_bin_index[AW-1:0];
    end

    rgbhk_hist_bank #(
        .BIN_COUNT  (BIN_COUNT),
        .COUNT_BITS (COUNT_BITS)
    ) u_bank_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (accept),
        .i_op    (op_red),
        .i_addr  (addr_red),
        .o_count (cnt_red)
    );

    rgbhk_hist_bank #(
        .BIN_COUNT  (BIN_COUNT),
        .COUNT_BITS (COUNT_BITS)
    ) u_bank_green (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (accept),
        .i_op    (op_green),
        .i_addr  (addr_green),
        .o_count (cnt_green)
    );

    rgbhk_hist_bank #(
        .BIN_COUNT  (BIN_COUNT),
        .COUNT_BITS (COUNT_BITS)
    ) u_bank_blue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (accept),
        .i_op    (op_blue),
        .i_addr  (addr_blue),
        .o_count (cnt_blue)
    );

    rgbhk_key u_key (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wen  (i_cfg_wen),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_red      (i_pix_red),
        .i_green    (i_pix_green),
        .i_blue     (i_pix_blue),
        .o_pix      (key_pix)
    );

    // Read requests carry a zero pixel.
    assign n_s1_pix = is_pix ? key_pix : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix <= n_s1_pix;
        end
    end

    // Stage one joins the keyed pixel with the bin counts.
    always_comb begin
        s1_res.pix         = r_s1_pix;
        s1_res.count_red   = cnt_red;
        s1_res.count_green = cnt_green;
        s1_res.count_blue  = cnt_blue;
    end

    rgbhk_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_v),
        .i_data  (s1_res),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (head),
        .o_level (level)
    );

    assign o_out_red     = head.pix.red;
    assign o_out_green   = head.pix.green;
    assign o_out_blue    = head.pix.blue;
    assign o_was_keyed   = head.pix.keyed;
    assign o_count_red   = head.count_red;
    assign o_count_green = head.count_green;
    assign o_count_blue  = head.count_blue;

endmodule
